// File: rtl/rlcps_pkg.sv
`timescale 1ns / 1ps

package rlcps_pkg;

	localparam int TIME_BITS = 16;
	localparam int MAX_STEPS = 4;
	localparam int CUE_COUNT = 6;
	localparam int ROM_STEPS = 4;
	localparam int HOLD_BITS = 16;
	localparam int CMP_BITS  = (TIME_BITS > HOLD_BITS) ? TIME_BITS : HOLD_BITS;
	localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;
	localparam logic [HOLD_BITS-1:0] HOLD_RESET = 16'd5000;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [2:0]           cue_t;
	typedef logic [1:0]           sidx_t;
	typedef logic [4:0]           cnt_t;
	typedef logic [7:0]           level_t;

	localparam cue_t CUE_NONE      = 3'd0;
	localparam cue_t CUE_ARMED     = 3'd1;
	localparam cue_t CUE_CANCELLED = 3'd2;
	localparam cue_t CUE_SENT      = 3'd3;
	localparam cue_t CUE_ACKED     = 3'd4;
	localparam cue_t CUE_LOW_BATT  = 3'd5;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_PLAY  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef struct packed {
		cue_t  cue;
		sidx_t step;
		logic  lit;
		time_t remain;
		time_t elapsed;
	} seq_state_t;

	typedef struct packed {
		level_t red;
		level_t green;
		level_t blue;
		logic   busy;
	} led_result_t;

	localparam logic [15:0] ROM_ON [CUE_COUNT][ROM_STEPS] = '{
		'{16'd0,    16'd0,   16'd0,  16'd0},
		'{16'd90,   16'd90,  16'd90, 16'd0},
		'{16'd700,  16'd0,   16'd0,  16'd0},
		'{16'd2000, 16'd0,   16'd0,  16'd0},
		'{16'd160,  16'd160, 16'd0,  16'd0},
		'{16'd60,   16'd0,   16'd0,  16'd0}
	};

	localparam logic [15:0] ROM_OFF [CUE_COUNT][ROM_STEPS] = '{
		'{16'd0,   16'd0,   16'd0, 16'd0},
		'{16'd90,  16'd90,  16'd0, 16'd0},
		'{16'd0,   16'd0,   16'd0, 16'd0},
		'{16'd0,   16'd0,   16'd0, 16'd0},
		'{16'd140, 16'd900, 16'd0, 16'd0},
		'{16'd0,   16'd0,   16'd0, 16'd0}
	};

	localparam logic [2:0] ROM_LEN [CUE_COUNT] = '{3'd0, 3'd3, 3'd1, 3'd1, 3'd2, 3'd1};

	localparam level_t ROM_RGB [CUE_COUNT][3] = '{
		'{8'd0,   8'd0,   8'd0},
		'{8'd255, 8'd100, 8'd0},
		'{8'd255, 8'd0,   8'd0},
		'{8'd255, 8'd0,   8'd50},
		'{8'd0,   8'd255, 8'd0},
		'{8'd255, 8'd0,   8'd0}
	};

	function automatic time_t clamp_time(logic [15:0] v);
		if (64'(v) > TIME_MAX)
			return TIME_BITS'(TIME_MAX);
		return TIME_BITS'(v);
	endfunction

	function automatic time_t on_time(cue_t c, sidx_t s);
		if (c >= cue_t'(CUE_COUNT))
			return '0;
		return clamp_time(ROM_ON[c][s]);
	endfunction

	function automatic time_t off_time(cue_t c, sidx_t s);
		if (c >= cue_t'(CUE_COUNT))
			return '0;
		return clamp_time(ROM_OFF[c][s]);
	endfunction

	function automatic cnt_t steps_of(cue_t c);
		cnt_t n;
		n = (c < cue_t'(CUE_COUNT)) ? cnt_t'(ROM_LEN[c]) : '0;
		if (n > cnt_t'(MAX_STEPS))
			n = cnt_t'(MAX_STEPS);
		return n;
	endfunction

endpackage

// File: rtl/rgb_led_cue_pattern_sequencer.sv
`timescale 1ns / 1ps
// Channel  | Handshake              | Word
// ---------+------------------------+---------------------------------------------
// input    | in_valid / in_ready    | opcode, cue
// output   | out_valid / out_ready  | red_level, green_level, blue_level, is_busy
// config   | cfg_wr_en              | cfg_wr_data (ack_hold_ms)
//
// One word is taken per clock while in_ready is high; its result is in the output register on the next edge.
// The sequencer state and the output register are updated at the same edge, and
// throughput is one word per cycle unless the output register is full and not being taken.
// in_ready is high while the output register is empty or being taken this cycle.
// arst_n clears the sequencer to idle and ack_hold_ms to 5000.

module rgb_led_cue_pattern_sequencer import rlcps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [2:0]           cue,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           red_level,
	output logic [7:0]           green_level,
	output logic [7:0]           blue_level,
	output logic                 is_busy,
	input  logic                 cfg_wr_en,
	input  logic [HOLD_BITS-1:0] cfg_wr_data
);

	seq_state_t            state_q;
	seq_state_t            state_nxt;
	led_result_t           result;
	led_result_t           result_q;
	logic                  out_valid_q;
	logic [HOLD_BITS-1:0]  hold_q;
	logic                  accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	rlcps_next u_next (
		.cur         (state_q),
		.opcode      (opcode),
		.cue         (cue),
		.ack_hold_ms (hold_q),
		.nxt         (state_nxt),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
			hold_q      <= HOLD_RESET;
		end else begin
			if (cfg_wr_en)
				hold_q <= cfg_wr_data;
			if (accept) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			result_q <= result;
	end

	assign out_valid   = out_valid_q;
	assign red_level   = result_q.red;
	assign green_level = result_q.green;
	assign blue_level  = result_q.blue;
	assign is_busy     = result_q.busy;

	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.busy |->
			(result_q.red == '0 && result_q.green == '0 && result_q.blue == '0))
		else $error("idle result carries a colour");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cue == CUE_NONE |-> (!state_q.lit && state_q.remain == '0))
		else $error("idle sequencer holds phase state");

	a_cue_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cue <= CUE_LOW_BATT)
		else $error("active cue out of range");

	a_play_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == OP_PLAY && cue == CUE_LOW_BATT |=>
			(state_q.cue == CUE_LOW_BATT && state_q.lit && is_busy))
		else $error("highest cue failed to take over");

endmodule

// File: rtl/rlcps_next.sv
`timescale 1ns / 1ps

module rlcps_next import rlcps_pkg::*; (
	input  seq_state_t             cur,
	input  logic [1:0]             opcode,
	input  cue_t                   cue,
	input  logic [HOLD_BITS-1:0]   ack_hold_ms,
	output seq_state_t             nxt,
	output led_result_t            result
);

	seq_state_t tk;
	seq_state_t idle;
	logic       hold_on;
	cnt_t       n_steps;
	cnt_t       step_inc;
	time_t      off_ms;
	time_t      dec_remain;

	always_comb begin
		idle         = cur;
		idle.cue     = CUE_NONE;
		idle.step    = '0;
		idle.lit     = 1'b0;
		idle.remain  = '0;

		// Tick: the elapsed count saturates, the phase count stops at zero.
		tk         = cur;
		tk.elapsed = (64'(cur.elapsed) < TIME_MAX) ? cur.elapsed + time_t'(1) : cur.elapsed;
		dec_remain = (cur.remain != '0) ? cur.remain - time_t'(1) : cur.remain;
		tk.remain  = dec_remain;

		hold_on  = (cur.cue == CUE_ACKED) && (ack_hold_ms != '0) &&
			(CMP_BITS'(tk.elapsed) < CMP_BITS'(ack_hold_ms));
		n_steps  = steps_of(cur.cue);
		step_inc = cnt_t'(cur.step) + cnt_t'(1);
		off_ms   = off_time(cur.cue, cur.step);

		if (dec_remain == '0) begin
			if (cur.lit) begin
				if (off_ms == '0 && step_inc >= n_steps) begin
					if (hold_on) begin
						tk.step   = '0;
						tk.lit    = 1'b1;
						tk.remain = on_time(cur.cue, '0);
					end else begin
						tk.cue    = CUE_NONE;
						tk.step   = '0;
						tk.lit    = 1'b0;
						tk.remain = '0;
					end
				end else begin
					tk.lit    = 1'b0;
					tk.remain = off_ms;
				end
			end else begin
				if (step_inc >= n_steps) begin
					if (hold_on) begin
						tk.step   = '0;
						tk.lit    = 1'b1;
						tk.remain = on_time(cur.cue, '0);
					end else begin
						tk.cue    = CUE_NONE;
						tk.step   = '0;
						tk.lit    = 1'b0;
						tk.remain = '0;
					end
				end else begin
					tk.step   = step_inc[1:0];
					tk.lit    = 1'b1;
					tk.remain = on_time(cur.cue, step_inc[1:0]);
				end
			end
		end

		nxt = cur;
		unique case (opcode)
			OP_TICK: begin
				if (cur.cue != CUE_NONE)
					nxt = tk;
			end
			OP_PLAY: begin
				if (cue != CUE_NONE && cue < cue_t'(CUE_COUNT) &&
					(cur.cue == CUE_NONE || cue > cur.cue)) begin
					nxt.cue     = cue;
					nxt.step    = '0;
					nxt.lit     = 1'b1;
					nxt.elapsed = '0;
					nxt.remain  = on_time(cue, '0);
				end
			end
			OP_CLEAR: nxt = idle;
			default:  nxt = cur;
		endcase

		if (nxt.cue != CUE_NONE && nxt.cue < cue_t'(CUE_COUNT) && nxt.lit) begin
			result.red   = ROM_RGB[nxt.cue][0];
			result.green = ROM_RGB[nxt.cue][1];
			result.blue  = ROM_RGB[nxt.cue][2];
		end else begin
			result.red   = '0;
			result.green = '0;
			result.blue  = '0;
		end
		result.busy = (nxt.cue != CUE_NONE);
	end

endmodule

// File: bench/rgb_led_cue_pattern_sequencer_tb.sv
`timescale 1ns / 1ps

module rgb_led_cue_pattern_sequencer_tb;
	import rlcps_pkg::*;

	localparam logic [1:0]     OP_UNUSED         = 2'd3;
	localparam cue_t           CUE_SIX           = 3'd6;
	localparam cue_t           CUE_SEVEN         = 3'd7;
	localparam logic [15:0]    ACK_HOLD_AT_RESET = 16'd5000;
	localparam int             WATCHDOG_LIMIT    = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           opcode = OP_TICK;
	cue_t                 cue = CUE_NONE;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           red_level;
	logic [7:0]           green_level;
	logic [7:0]           blue_level;
	logic                 is_busy;
	logic                 cfg_wr_en = 1'b0;
	logic [HOLD_BITS-1:0] cfg_wr_data = '0;

	// Predicted sequencer state, kept in step with every accepted word.
	cue_t        lamp_cue = CUE_NONE;
	int unsigned lamp_step = 0;
	logic        lamp_lit = 1'b0;
	time_t       lamp_remain = '0;
	time_t       lamp_elapsed = '0;
	logic [15:0] hold_ms = ACK_HOLD_AT_RESET;

	led_result_t pending_leds[$];
	int          err_count = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          rx_mode = 0;
	int          rx_left = 0;
	int unsigned rx_count = 0;

	rgb_led_cue_pattern_sequencer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.cue         (cue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level),
		.is_busy     (is_busy),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned pattern_len(cue_t c);
		int unsigned n;
		case (c) inside
			CUE_ARMED:                           n = 3;
			CUE_ACKED:                           n = 2;
			CUE_CANCELLED, CUE_SENT, CUE_LOW_BATT: n = 1;
			default:                             n = 0;
		endcase
		if (n > MAX_STEPS)
			n = MAX_STEPS;
		return n;
	endfunction

	function automatic int unsigned pattern_on(cue_t c, int unsigned s);
		case (c)
			CUE_ARMED:     return (s < 3) ? 90 : 0;
			CUE_CANCELLED: return (s == 0) ? 700 : 0;
			CUE_SENT:      return (s == 0) ? 2000 : 0;
			CUE_ACKED:     return (s < 2) ? 160 : 0;
			CUE_LOW_BATT:  return (s == 0) ? 60 : 0;
			default:       return 0;
		endcase
	endfunction

	function automatic int unsigned pattern_off(cue_t c, int unsigned s);
		case (c)
			CUE_ARMED: return (s < 2) ? 90 : 0;
			CUE_ACKED: return (s == 0) ? 140 : ((s == 1) ? 900 : 0);
			default:   return 0;
		endcase
	endfunction

	function automatic led_result_t cue_colour(cue_t c);
		led_result_t r;
		r = '0;
		case (c) inside
			CUE_ARMED:                   begin r.red = 8'd255; r.green = 8'd100; end
			CUE_CANCELLED, CUE_LOW_BATT: r.red = 8'd255;
			CUE_SENT:                    begin r.red = 8'd255; r.blue = 8'd50; end
			CUE_ACKED:                   r.green = 8'd255;
			default:                     r = '0;
		endcase
		return r;
	endfunction

	function automatic void go_dark();
		lamp_cue = CUE_NONE;
		lamp_step = 0;
		lamp_lit = 1'b0;
		lamp_remain = '0;
	endfunction

	function automatic bit ack_repeats();
		return lamp_cue == CUE_ACKED && hold_ms != 16'd0 && lamp_elapsed < hold_ms;
	endfunction

	function automatic void finish_phase();
		int unsigned n;
		int unsigned off;
		n = pattern_len(lamp_cue);
		if (lamp_lit) begin
			off = pattern_off(lamp_cue, lamp_step);
			lamp_lit = 1'b0;
			if (off == 0 && lamp_step + 1 >= n) begin
				// Last step with no dark time: the pattern is complete.
				if (ack_repeats()) begin
					lamp_step = 0;
					lamp_lit = 1'b1;
					lamp_remain = time_t'(pattern_on(lamp_cue, 0));
				end else begin
					go_dark();
				end
			end else begin
				lamp_remain = time_t'(off);
			end
		end else begin
			lamp_step = lamp_step + 1;
			if (lamp_step >= n && !ack_repeats()) begin
				go_dark();
			end else begin
				if (lamp_step >= n)
					lamp_step = 0;
				lamp_lit = 1'b1;
				lamp_remain = time_t'(pattern_on(lamp_cue, lamp_step));
			end
		end
	endfunction

	function automatic void advance_sequencer(logic [1:0] op, cue_t c);
		led_result_t r;
		if (op == OP_TICK) begin
			if (lamp_cue != CUE_NONE) begin
				if (lamp_elapsed != '1)
					lamp_elapsed = lamp_elapsed + 1'b1;
				if (lamp_remain != '0)
					lamp_remain = lamp_remain - 1'b1;
				if (lamp_remain == '0)
					finish_phase();
			end
		end else if (op == OP_PLAY) begin
			if (c != CUE_NONE && c < CUE_SIX && (lamp_cue == CUE_NONE || c > lamp_cue)) begin
				lamp_cue = c;
				lamp_step = 0;
				lamp_lit = 1'b1;
				lamp_elapsed = '0;
				lamp_remain = time_t'(pattern_on(c, 0));
			end
		end else if (op == OP_CLEAR) begin
			go_dark();
		end
		r = lamp_lit ? cue_colour(lamp_cue) : '0;
		r.busy = (lamp_cue != CUE_NONE);
		pending_leds.push_back(r);
	endfunction

	task automatic send_word(input logic [1:0] op, input cue_t c);
		bit rdy;
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		opcode <= op;
		cue <= c;
		rdy = 1'b0;
		// in_ready is settled by the falling edge and holds until the next rising one.
		while (!rdy) begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end
		burst_left--;
		advance_sequencer(op, c);
	endtask

	task automatic send_tick();
		send_word(OP_TICK, cue_t'($urandom_range(0, 7)));
	endtask

	task automatic send_noise();
		send_word(2'($urandom_range(0, 3)), cue_t'($urandom_range(0, 7)));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (pending_leds.size() != 0);
	endtask

	task automatic write_hold(input logic [15:0] value);
		wait_drained();
		repeat (2) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		hold_ms = value;
	endtask

	task automatic tick_until_idle(input int limit);
		int n;
		n = 0;
		while (lamp_cue != CUE_NONE && n < limit) begin
			send_tick();
			n++;
		end
	endtask

	task automatic test_idle_words();
		send_word(OP_TICK, CUE_SEVEN);
		send_word(OP_CLEAR, CUE_NONE);
		send_word(OP_UNUSED, CUE_ARMED);
		send_word(OP_PLAY, CUE_NONE);
		send_word(OP_PLAY, CUE_SIX);
		send_word(OP_PLAY, CUE_SEVEN);
	endtask

	task automatic test_cue_priority();
		send_word(OP_PLAY, CUE_ARMED);
		send_word(OP_PLAY, CUE_ARMED);
		send_tick();
		send_word(OP_PLAY, CUE_CANCELLED);
		send_word(OP_PLAY, CUE_ARMED);
		send_word(OP_PLAY, CUE_SENT);
		send_word(OP_PLAY, CUE_LOW_BATT);
		send_word(OP_PLAY, CUE_ACKED);
		send_word(OP_PLAY, CUE_SEVEN);
		send_tick();
		send_word(OP_UNUSED, CUE_LOW_BATT);
		send_word(OP_CLEAR, CUE_SEVEN);
		send_tick();
	endtask

	task automatic test_full_patterns();
		write_hold(16'd0);
		send_word(OP_PLAY, CUE_LOW_BATT);
		tick_until_idle(100);
		send_tick();
	endtask

	task automatic test_ack_repeat();
		// One pass of the acked pattern lasts 1360 ms, so this hold repeats it once.
		write_hold(16'd1361);
		send_word(OP_PLAY, CUE_ACKED);
		repeat (1370) send_tick();
		send_word(OP_CLEAR, CUE_NONE);
		send_tick();
	endtask

	task automatic test_random_traffic();
		logic [15:0] holds [4];
		int sent;
		int run;
		int n;
		holds[0] = 16'd1;
		holds[1] = 16'($urandom_range(0, 4000));
		holds[2] = 16'hFFFF;
		holds[3] = 16'($urandom_range(100, 2000));
		for (int p = 0; p < 4; p++) begin
			write_hold(holds[p]);
			sent = 0;
			while (sent < 100) begin
				if ($urandom_range(0, 4) != 0) begin
					send_word(OP_PLAY, cue_t'($urandom_range(1, 5)));
					sent++;
					run = $urandom_range(1, 120);
					n = 0;
					while (n < run && lamp_cue != CUE_NONE && sent < 100) begin
						if ($urandom_range(0, 24) == 0)
							send_noise();
						else
							send_tick();
						n++;
						sent++;
					end
				end else begin
					send_noise();
					sent++;
				end
				if ($urandom_range(0, 9) == 0)
					wait_drained();
			end
		end
	endtask

	// Receiver: picks a new random stall pattern each time its run counter runs out.
	always @(posedge clk) begin
		rx_count <= rx_count + 1;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_left <= $urandom_range(16, 128);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= (rx_count % 5) > 1;
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(negedge clk) begin
		led_result_t got;
		led_result_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (out_valid && out_ready) begin
				got.red = red_level;
				got.green = green_level;
				got.blue = blue_level;
				got.busy = is_busy;
				if (pending_leds.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("Unexpected word: r %0d g %0d b %0d busy %0b",
							got.red, got.green, got.blue, got.busy);
				end else begin
					want = pending_leds.pop_front();
					if (got !== want) begin
						err_count++;
						if (err_count <= 10)
							$display("Mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_words();
		test_cue_priority();
		test_full_patterns();
		test_ack_repeat();
		test_random_traffic();
		wait_drained();
		repeat (4) @(posedge clk);
		if (err_count == 0 && pending_leds.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
